// ===== design/threshold_top_k_hit_selector_defines.svh =====
// Assertion macros for the threshold top-k hit selector.
`ifndef THRESHOLD_TOP_K_HIT_SELECTOR_DEFINES_SVH
`define THRESHOLD_TOP_K_HIT_SELECTOR_DEFINES_SVH

`ifndef SYNTHESIS
`define THK_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: check failed");
`define THK_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: check failed");
`else
`define THK_ASSERT_NOW(lbl, clk, rst, ante, cons)
`define THK_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif

`endif

// ===== design/thk_pkg.sv =====
`default_nettype none
package thk_pkg;

   localparam int HIT_SLOTS = 16;
   localparam int SLOT_W    = $clog2(HIT_SLOTS);
   localparam int CNT_W     = $clog2(HIT_SLOTS + 1);
   localparam int LIMIT_W   = 5;
   localparam int LIM_W     = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;
   localparam int FRAC_W    = 17;
   localparam int DATA_W    = 16;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_W     = 17;

   localparam logic [CSR_IDX_W-1:0] CSR_SHOT_FRACTION = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_KEEP_LIMIT    = 1'd1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECIDE,
      ST_MIN_SCAN,
      ST_REPLACE,
      ST_WRAP,
      ST_SORT_SCAN,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic [DATA_W-1:0] bin;
      logic [DATA_W-1:0] hits;
   } slot_type;

   typedef struct packed {
      logic              we;
      logic [SLOT_W-1:0] waddr;
      slot_type          wdata;
      logic [SLOT_W-1:0] raddr;
   } ram_req_type;

   typedef struct packed {
      logic              valid;
      logic [DATA_W-1:0] bin;
      logic [DATA_W-1:0] hits;
      logic              unclassified;
      logic              last;
   } push_type;

   typedef struct packed {
      logic             busy;
      logic [CNT_W-1:0] used;
   } status_type;

endpackage
`default_nettype wire

// ===== design/thk_slot_ram.sv =====
`default_nettype none
module thk_slot_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule
`default_nettype wire

// ===== design/thk_thresh.sv =====
`default_nettype none
module thk_thresh
   import thk_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              load,
   input  wire logic [FRAC_W-1:0] fraction,
   input  wire logic [DATA_W-1:0] total,
   input  wire logic [DATA_W-1:0] hits,
   output logic                   pass
);

   localparam int PROD_W = FRAC_W + DATA_W;
   localparam int THR_W  = PROD_W + 1 - 16;

   logic [PROD_W-1:0] prod_ff;
   logic [DATA_W-1:0] hits_ff;
   logic              total_zero_ff;
   logic [PROD_W:0]   round_sum;
   logic [THR_W-1:0]  thr;

   always_ff @(posedge clock) begin
      if (load) begin
         prod_ff       <= PROD_W'(fraction) * PROD_W'(total);
         hits_ff       <= hits;
         total_zero_ff <= (total == '0);
      end
   end

   // ceil(fraction * total / 2^16)
   assign round_sum = {1'b0, prod_ff} + (PROD_W + 1)'(16'hFFFF);
   assign thr       = round_sum[PROD_W:16];

   assign pass = (hits_ff != '0) && !total_zero_ff &&
                 ((thr == '0) || (THR_W'(hits_ff) >= thr));

endmodule
`default_nettype wire

// ===== design/thk_ctrl.sv =====
`default_nettype none
module thk_ctrl
   import thk_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_accept,
   input  wire logic [DATA_W-1:0]  req_bin,
   input  wire logic [DATA_W-1:0]  req_hits,
   input  wire logic               req_last,
   input  wire logic [LIMIT_W-1:0] keep_limit,
   input  wire logic               pass,
   input  wire slot_type           ram_rdata,
   input  wire logic               out_free,
   output ram_req_type             ram_req,
   output push_type                push,
   output status_type              status
);

   state_type state_ff, state_in;

   logic [DATA_W-1:0] bin_ff;
   logic [DATA_W-1:0] hits_ff;
   logic              last_ff;
   logic [CNT_W-1:0]  used_ff;
   logic [CNT_W-1:0]  left_ff;
   logic [CNT_W-1:0]  scan_ff;
   logic              rd_vld_ff;
   logic [SLOT_W-1:0] rd_idx_ff;
   logic              have_ff;
   logic [DATA_W-1:0] best_hits_ff;
   logic [DATA_W-1:0] best_bin_ff;
   logic [SLOT_W-1:0] best_idx_ff;
   logic [HIT_SLOTS-1:0] done_ff;

   logic [LIM_W-1:0] lim;
   logic             full;
   logic             in_scan;
   logic             scan_adv;
   logic             scan_done;
   logic             take_min;
   logic             take_max;
   logic             take;
   logic             append;
   logic             replace;
   logic             emit_end;

   always_comb begin
      if ((keep_limit == '0) || (LIM_W'(keep_limit) > LIM_W'(HIT_SLOTS))) begin
         lim = LIM_W'(HIT_SLOTS);
      end else begin
         lim = LIM_W'(keep_limit);
      end
   end

   assign full      = LIM_W'(used_ff) >= lim;
   assign in_scan   = (state_ff == ST_MIN_SCAN) || (state_ff == ST_SORT_SCAN);
   assign scan_adv  = scan_ff < used_ff;
   assign scan_done = (scan_ff == used_ff) && !rd_vld_ff;
   assign take_min  = (state_ff == ST_MIN_SCAN) && rd_vld_ff &&
                      (!have_ff || (ram_rdata.hits < best_hits_ff));
   assign take_max  = (state_ff == ST_SORT_SCAN) && rd_vld_ff && !done_ff[rd_idx_ff] &&
                      (!have_ff || (ram_rdata.hits > best_hits_ff));
   assign take      = take_min || take_max;
   assign append    = (state_ff == ST_DECIDE) && pass && !full;
   assign replace   = (state_ff == ST_REPLACE) && (hits_ff > best_hits_ff);
   assign emit_end  = (used_ff == '0) || (left_ff == CNT_W'(1));

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            if (pass && full && (used_ff != '0)) begin
               state_in = ST_MIN_SCAN;
            end else begin
               state_in = ST_WRAP;
            end
         end
         ST_MIN_SCAN: begin
            if (scan_done) begin
               state_in = ST_REPLACE;
            end
         end
         ST_REPLACE: begin
            state_in = ST_WRAP;
         end
         ST_WRAP: begin
            if (!last_ff) begin
               state_in = ST_IDLE;
            end else if (used_ff == '0) begin
               state_in = ST_EMIT;
            end else begin
               state_in = ST_SORT_SCAN;
            end
         end
         ST_SORT_SCAN: begin
            if (scan_done) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               state_in = emit_end ? ST_IDLE : ST_SORT_SCAN;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Writes happen only in states that do not read, so no forwarding is needed.
   always_comb begin
      ram_req.we    = append || replace;
      ram_req.waddr = append ? used_ff[SLOT_W-1:0] : best_idx_ff;
      ram_req.wdata = '{bin: bin_ff, hits: hits_ff};
      ram_req.raddr = scan_ff[SLOT_W-1:0];
   end

   always_comb begin
      push.valid = (state_ff == ST_EMIT) && out_free;
      if (used_ff == '0) begin
         push.bin          = '0;
         push.hits         = DATA_W'(1);
         push.unclassified = 1'b1;
         push.last         = 1'b1;
      end else begin
         push.bin          = best_bin_ff;
         push.hits         = best_hits_ff;
         push.unclassified = 1'b0;
         push.last         = (left_ff == CNT_W'(1));
      end
   end

   assign status.busy = (state_ff != ST_IDLE);
   assign status.used = used_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         used_ff   <= '0;
         scan_ff   <= '0;
         rd_vld_ff <= 1'b0;
         have_ff   <= 1'b0;
         done_ff   <= '0;
      end else begin
         state_ff <= state_in;

         if (append) begin
            used_ff <= used_ff + CNT_W'(1);
         end else if (push.valid && emit_end) begin
            used_ff <= '0;
         end

         if (in_scan) begin
            scan_ff   <= scan_ff + CNT_W'(scan_adv);
            rd_vld_ff <= scan_adv;
            if (take) begin
               have_ff <= 1'b1;
            end
         end else begin
            scan_ff   <= '0;
            rd_vld_ff <= 1'b0;
            have_ff   <= 1'b0;
         end

         if (state_ff == ST_WRAP) begin
            done_ff <= '0;
         end else if (push.valid) begin
            done_ff[best_idx_ff] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         bin_ff  <= req_bin;
         hits_ff <= req_hits;
         last_ff <= req_last;
      end
      rd_idx_ff <= scan_ff[SLOT_W-1:0];
      if (take) begin
         best_hits_ff <= ram_rdata.hits;
         best_bin_ff  <= ram_rdata.bin;
         best_idx_ff  <= rd_idx_ff;
      end
      if (state_ff == ST_WRAP) begin
         left_ff <= used_ff;
      end else if (push.valid) begin
         left_ff <= left_ff - CNT_W'(1);
      end
   end

endmodule
`default_nettype wire

// ===== design/threshold_top_k_hit_selector.sv =====
// Flow: a bin that is stored or dropped passes ST_DECIDE and ST_WRAP; a passing bin offered
// to a full store also passes ST_MIN_SCAN, a scan of the n slots in use, and ST_REPLACE.
// Readout after the last bin: one RAM pass per result (ST_SORT_SCAN, then ST_EMIT), none if
// the read is unclassified. One request is in flight at a time; the result register
// lets the next request enter while the final result waits to be taken.
// Reset clears control, slot count, CSRs and rsp_valid; slot RAM and data stay undefined.
`default_nettype none
`include "threshold_top_k_hit_selector_defines.svh"
module threshold_top_k_hit_selector
   import thk_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 csr_write,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [CSR_W-1:0]     csr_wdata,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire logic [DATA_W-1:0]    req_bin_index,
   input  wire logic [DATA_W-1:0]    req_bin_hits,
   input  wire logic [DATA_W-1:0]    req_hash_total,
   input  wire logic                 req_last_bin,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output logic [DATA_W-1:0]         rsp_out_bin,
   output logic [DATA_W-1:0]         rsp_out_hits,
   output logic                      rsp_unclassified,
   output logic                      rsp_last_result
);

   logic [FRAC_W-1:0]  shot_fraction_ff;
   logic [LIMIT_W-1:0] keep_limit_ff;
   logic               rsp_valid_ff;
   push_type           rsp_ff;

   logic               req_accept;
   logic               out_free;
   logic               pass;
   logic [$bits(slot_type)-1:0] ram_rdata;
   ram_req_type        ram_req;
   push_type           ctrl_push;
   status_type         ctrl_status;
   logic               uncl_form_ok;

   assign req_stall  = ctrl_status.busy;
   assign req_accept = req_valid && !req_stall;
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         shot_fraction_ff <= '0;
         keep_limit_ff    <= '0;
      end else if (csr_write) begin
         case (csr_index)
            CSR_SHOT_FRACTION: shot_fraction_ff <= csr_wdata[FRAC_W-1:0];
            CSR_KEEP_LIMIT:    keep_limit_ff    <= csr_wdata[LIMIT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   thk_thresh u_thresh (
      .clock    (clock),
      .load     (req_accept),
      .fraction (shot_fraction_ff),
      .total    (req_hash_total),
      .hits     (req_bin_hits),
      .pass     (pass)
   );

   thk_slot_ram #(
      .WIDTH ($bits(slot_type)),
      .DEPTH (HIT_SLOTS)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (ram_req.we),
      .wr_addr (ram_req.waddr),
      .wr_data (ram_req.wdata),
      .rd_addr (ram_req.raddr),
      .rd_data (ram_rdata)
   );

   thk_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_accept (req_accept),
      .req_bin    (req_bin_index),
      .req_hits   (req_bin_hits),
      .req_last   (req_last_bin),
      .keep_limit (keep_limit_ff),
      .pass       (pass),
      .ram_rdata  (slot_type'(ram_rdata)),
      .out_free   (out_free),
      .ram_req    (ram_req),
      .push       (ctrl_push),
      .status     (ctrl_status)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ctrl_push.valid) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl_push.valid) begin
         rsp_ff <= ctrl_push;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_out_bin      = rsp_ff.bin;
   assign rsp_out_hits     = rsp_ff.hits;
   assign rsp_unclassified = rsp_ff.unclassified;
   assign rsp_last_result  = rsp_ff.last;

   assign uncl_form_ok = rsp_last_result && (rsp_out_hits == DATA_W'(1)) &&
                         (rsp_out_bin == '0);

   `THK_ASSERT_NEXT(a_busy_after_req, clock, reset, req_accept, req_stall)
   `THK_ASSERT_NOW(a_push_needs_room, clock, reset, ctrl_push.valid, out_free)
   `THK_ASSERT_NOW(a_used_bound, clock, reset, 1'b1, ctrl_status.used <= CNT_W'(HIT_SLOTS))
   `THK_ASSERT_NOW(a_unclass_form, clock, reset, rsp_valid && rsp_unclassified, uncl_form_ok)

endmodule
`default_nettype wire
